// ===== rtl/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared constants, types and helper functions of the world-to-screen
// projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

   // fixed-point formats
   localparam int POS_FRAC_BITS = 8;
   localparam int MAT_FRAC_BITS = 16;
   localparam int MAT_DOWN = (MAT_FRAC_BITS > POS_FRAC_BITS) ?
                             (MAT_FRAC_BITS - POS_FRAC_BITS) : 0;
   localparam int MAT_UP   = (POS_FRAC_BITS > MAT_FRAC_BITS) ?
                             (POS_FRAC_BITS - MAT_FRAC_BITS) : 0;

   // shared multiplier operand and product widths
   localparam int MUL_OP_W   = 33;
   localparam int MUL_PROD_W = 2 * MUL_OP_W;

   // shared divider widths
   localparam int DIV_NUM_W   = 48;
   localparam int DIV_DEN_W   = 33;
   localparam int DIV_STEPS   = DIV_NUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // w / 100 in world units: (|w| >> POS_FRAC_BITS) times ceil(2^38 / 100),
   // shifted down by 38; exact for any operand below 2^32
   localparam int          DIST_SHIFT = 38;
   localparam logic [31:0] DIST_RECIP = 32'(((64'd1 << DIST_SHIFT) + 64'd99) / 64'd100);

   // input item kinds
   localparam logic ACTION_LOAD    = 1'b0;
   localparam logic ACTION_PROJECT = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_PROJ_MODE     = 3'd2;
   localparam logic [2:0] CSR_HEAD_LIFT     = 3'd3;
   localparam logic [2:0] CSR_FOOT_DROP     = 3'd4;

   // configuration reset values
   localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd1920;
   localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd1080;
   localparam logic [15:0] HEAD_LIFT_RST     = 16'd85;
   localparam logic [15:0] FOOT_DROP_RST     = 16'd95;

   localparam logic MODE_PLAIN = 1'b0;
   localparam logic MODE_BOX   = 1'b1;

   // matrix entry (2,1), used for the box lift and drop
   localparam logic [3:0] MAT_M21_INDEX = 4'd9;

   // divider status back to the sequencer
   typedef struct packed {
      logic done;
      logic rem_nz;
   } wsp_div_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // matrix format to position format, floored
   function automatic logic signed [63:0] mat_to_pos(input logic signed [63:0] v);
      if (MAT_FRAC_BITS >= POS_FRAC_BITS) begin
         return v >>> MAT_DOWN;
      end
      return v <<< MAT_UP;
   endfunction

endpackage

// ===== rtl/world_to_screen_projection.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points against a stored 4x4 view matrix.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: tuser is the action (load matrix entry or project a point).
//   A load transfer writes one matrix entry at its accept edge and gives no
//   result. A project transfer gives exactly one rsp transfer.
//  rsp channel: tuser is the visible flag, tdata holds the screen position,
//   depth or box height and the distance.
//  csr port: write-only registers, written in any cycle with csr_we high.
//  Steps of a project item: multiply-accumulate on the shared multiplier (more
//   terms in box mode), w/100 by reciprocal multiply, then one pass of the
//   48-step shared divider each for x, y and the box bottom in box mode, then
//   a load of the output register; a hidden point skips the divider passes.
//   req_tready is low until the result is in the output register.
//  A result waiting in the output register is held while rsp_tready is low;
//  the next item is taken meanwhile, and its result waits for the register.
//  Reset clears the matrix to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // entry_index[3:0], entry_value[35:4], pos_x[67:36], pos_y[99:68],
   // pos_z[131:100], zero[135:132]
   input  logic [135:0]  req_tdata,
   // action[0]
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // screen_x[15:0], screen_y[31:16], depth_or_height[63:32], distance[87:64]
   output logic [87:0]   rsp_tdata,
   // visible[0]
   output logic [0:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_DIVGO = 4'd3;
   localparam logic [3:0] ST_DWAIT = 4'd4;
   localparam logic [3:0] ST_JMUL  = 4'd5;
   localparam logic [3:0] ST_DONE  = 4'd6;
   localparam logic [3:0] ST_DIST  = 4'd7;

   localparam logic [2:0] PASS_W    = 3'd0;
   localparam logic [2:0] PASS_X    = 3'd1;
   localparam logic [2:0] PASS_Y    = 3'd2;
   localparam logic [2:0] PASS_TOP  = 3'd3;
   localparam logic [2:0] PASS_BOT  = 3'd4;

   localparam logic [1:0] JOB_DIST = 2'd0;
   localparam logic [1:0] JOB_SX   = 2'd1;
   localparam logic [1:0] JOB_SY   = 2'd2;
   localparam logic [1:0] JOB_BOT  = 2'd3;

   localparam logic [1:0] TERM_CONST = 2'd3;

   // configuration
   logic [13:0]               width_ff, height_ff;
   logic                      mode_ff;
   logic [15:0]               lift_ff, drop_ff;

   // matrix
   logic signed [31:0]        mat_ff [16];
   logic [3:0]                mat_addr;
   logic signed [31:0]        mat_rd;
   logic [1:0]                col;

   // sequencer
   logic [3:0]                state_ff, state_in;
   logic [2:0]                pass_ff, pass_in;
   logic [1:0]                term_ff, term_in;
   logic [1:0]                job_ff, job_in;
   logic                      neg_ff, neg_in;

   // working values
   logic signed [31:0]        px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [51:0]        acc_ff, acc_in;
   logic signed [51:0]        yraw_ff, yraw_in;
   logic signed [31:0]        w_ff, w_in, xs_ff, xs_in, yv_ff, yv_in, bot_ff, bot_in;
   logic signed [23:0]        dist_ff, dist_in;
   logic signed [48:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic signed [31:0]        third_ff, third_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [87:0]               rsp_data_ff, rsp_data_in;
   logic                      rsp_vis_ff, rsp_vis_in;

   // shared units
   logic signed [wsp_pkg::MUL_OP_W-1:0]    mul_a, mul_b;
   logic signed [wsp_pkg::MUL_PROD_W-1:0]  mul_prod;
   logic signed [63:0]                     prod64;
   logic                                   div_start;
   logic [wsp_pkg::DIV_NUM_W-1:0]          div_num;
   logic [wsp_pkg::DIV_DEN_W-1:0]          div_den;
   logic [wsp_pkg::DIV_NUM_W-1:0]          div_quo;
   wsp_pkg::wsp_div_status_type            div_status;

   // scratch
   logic signed [63:0]        term_val, sum64, w64, mag64, quo64, fq64;
   logic signed [63:0]        wabs64, dist_q64, dist64;
   logic [31:0]               dist_n;
   logic                      vis;
   logic                      req_xfer;

   wsp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod)
   );

   wsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .status   (div_status)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign prod64     = mul_prod[63:0];
   assign w64        = 64'(w_ff);
   assign vis        = (w_ff > 32'sd0);

   // |w| in world units, operand of the w/100 reciprocal multiply
   assign wabs64 = w_ff[31] ? -w64 : w64;
   assign dist_n = wabs64[31:0] >> wsp_pkg::POS_FRAC_BITS;

   // matrix column for the running pass: w, X, Y
   always_comb begin
      case (pass_ff)
         PASS_W:  col = 2'd3;
         PASS_X:  col = 2'd0;
         default: col = 2'd1;
      endcase
      mat_addr = (pass_ff < PASS_TOP) ? {term_ff, col} : wsp_pkg::MAT_M21_INDEX;
      mat_rd   = mat_ff[mat_addr];
   end

   // multiplier operand select
   always_comb begin
      mul_a = {mat_rd[31], mat_rd};
      mul_b = '0;
      if (state_ff == ST_JMUL) begin
         case (job_ff)
            JOB_DIST: begin
               mul_a = {1'b0, dist_n};
               mul_b = {1'b0, wsp_pkg::DIST_RECIP};
            end
            JOB_SX: begin
               mul_a = {19'b0, width_ff};
               mul_b = {w_ff[31], w_ff} + {xs_ff[31], xs_ff};
            end
            JOB_SY: begin
               mul_a = {19'b0, height_ff};
               mul_b = {w_ff[31], w_ff} - {yv_ff[31], yv_ff};
            end
            default: begin
               mul_a = {19'b0, height_ff};
               mul_b = {w_ff[31], w_ff} - {bot_ff[31], bot_ff};
            end
         endcase
      end else begin
         case (pass_ff)
            PASS_TOP: mul_b = {17'b0, lift_ff};
            PASS_BOT: mul_b = {17'b0, drop_ff};
            default: begin
               case (term_ff)
                  2'd0:    mul_b = {px_ff[31], px_ff};
                  2'd1:    mul_b = {py_ff[31], py_ff};
                  2'd2:    mul_b = {pz_ff[31], pz_ff};
                  default: mul_b = 33'sd1;
               endcase
            end
         endcase
      end
   end

   // divider operand select: magnitude of the registered product over 2w
   always_comb begin
      div_start = (state_ff == ST_DIVGO);
      mag64     = prod64[63] ? -prod64 : prod64;
      div_den   = {w_ff, 1'b0};
      div_num   = mag64[wsp_pkg::DIV_NUM_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      term_in  = term_ff;
      job_in   = job_ff;
      neg_in   = neg_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      acc_in   = acc_ff;
      yraw_in  = yraw_ff;
      w_in     = w_ff;
      xs_in    = xs_ff;
      yv_in    = yv_ff;
      bot_in   = bot_ff;
      dist_in  = dist_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      third_in = third_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_vis_in   = rsp_vis_ff;

      term_val = (term_ff == TERM_CONST) ? wsp_pkg::mat_to_pos(prod64)
                                         : (prod64 >>> wsp_pkg::MAT_FRAC_BITS);
      sum64    = 64'(acc_ff) + term_val;
      quo64    = {16'b0, div_quo};
      fq64     = neg_ff ? -(quo64 + 64'(div_status.rem_nz)) : quo64;
      dist_q64 = prod64 >>> wsp_pkg::DIST_SHIFT;
      dist64   = w_ff[31] ? -dist_q64 : dist_q64;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser[0] == wsp_pkg::ACTION_PROJECT) begin
               px_in    = req_tdata[67:36];
               py_in    = req_tdata[99:68];
               pz_in    = req_tdata[131:100];
               acc_in   = '0;
               pass_in  = PASS_W;
               term_in  = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_MUL;
            case (pass_ff)
               PASS_TOP: begin
                  yv_in   = wsp_pkg::sat32(64'(yraw_ff) + wsp_pkg::mat_to_pos(prod64));
                  pass_in = PASS_BOT;
               end
               PASS_BOT: begin
                  bot_in   = wsp_pkg::sat32(64'(yraw_ff) - wsp_pkg::mat_to_pos(prod64));
                  job_in   = JOB_DIST;
                  state_in = ST_JMUL;
               end
               default: begin
                  if (term_ff != TERM_CONST) begin
                     acc_in  = sum64[51:0];
                     term_in = term_ff + 1'b1;
                  end else begin
                     acc_in  = '0;
                     term_in = 2'd0;
                     case (pass_ff)
                        PASS_W: begin
                           w_in    = wsp_pkg::sat32(sum64);
                           pass_in = PASS_X;
                        end
                        PASS_X: begin
                           xs_in   = wsp_pkg::sat32(sum64);
                           pass_in = PASS_Y;
                        end
                        default: begin
                           yraw_in = sum64[51:0];
                           yv_in   = wsp_pkg::sat32(sum64);
                           if (mode_ff == wsp_pkg::MODE_BOX) begin
                              pass_in = PASS_TOP;
                           end else begin
                              job_in   = JOB_DIST;
                              state_in = ST_JMUL;
                           end
                        end
                     endcase
                  end
               end
            endcase
         end
         ST_JMUL: begin
            state_in = (job_ff == JOB_DIST) ? ST_DIST : ST_DIVGO;
         end
         // w/100 truncated toward zero, saturated to 24 bits
         ST_DIST: begin
            if (dist64 > 64'sd8388607) begin
               dist_in = 24'sh7FFFFF;
            end else if (dist64 < -64'sd8388608) begin
               dist_in = 24'sh800000;
            end else begin
               dist_in = dist64[23:0];
            end
            job_in   = JOB_SX;
            state_in = vis ? ST_JMUL : ST_DONE;
         end
         ST_DIVGO: begin
            neg_in   = prod64[63];
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_status.done) begin
               case (job_ff)
                  JOB_SX: begin
                     sx_in    = fq64[48:0];
                     job_in   = JOB_SY;
                     state_in = ST_JMUL;
                  end
                  JOB_SY: begin
                     sy_in    = fq64[48:0];
                     job_in   = JOB_BOT;
                     state_in = (mode_ff == wsp_pkg::MODE_BOX) ? ST_JMUL : ST_DONE;
                  end
                  default: begin
                     third_in = wsp_pkg::sat32(fq64 - 64'(sy_ff));
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = vis;
               rsp_data_in[15:0]  = vis ? wsp_pkg::sat16(64'(sx_ff)) : 16'sd0;
               rsp_data_in[31:16] = vis ? wsp_pkg::sat16(64'(sy_ff)) : 16'sd0;
               if (mode_ff == wsp_pkg::MODE_PLAIN) begin
                  rsp_data_in[63:32] = w_ff;
               end else begin
                  rsp_data_in[63:32] = vis ? third_ff : 32'sd0;
               end
               rsp_data_in[87:64] = dist_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff     <= pass_in;
      term_ff     <= term_in;
      job_ff      <= job_in;
      neg_ff      <= neg_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      acc_ff      <= acc_in;
      yraw_ff     <= yraw_in;
      w_ff        <= w_in;
      xs_ff       <= xs_in;
      yv_ff       <= yv_in;
      bot_ff      <= bot_in;
      dist_ff     <= dist_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      third_ff    <= third_in;
      rsp_data_ff <= rsp_data_in;
      rsp_vis_ff  <= rsp_vis_in;
   end

   // matrix store, cleared at reset, written by load transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (req_xfer && req_tuser[0] == wsp_pkg::ACTION_LOAD) begin
         mat_ff[req_tdata[3:0]] <= req_tdata[35:4];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wsp_pkg::SCREEN_WIDTH_RST;
         height_ff <= wsp_pkg::SCREEN_HEIGHT_RST;
         mode_ff   <= wsp_pkg::MODE_PLAIN;
         lift_ff   <= wsp_pkg::HEAD_LIFT_RST;
         drop_ff   <= wsp_pkg::FOOT_DROP_RST;
      end else if (csr_we) begin
         case (csr_index)
            wsp_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[13:0];
            wsp_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[13:0];
            wsp_pkg::CSR_PROJ_MODE:     mode_ff   <= csr_wdata[0];
            wsp_pkg::CSR_HEAD_LIFT:     lift_ff   <= csr_wdata;
            wsp_pkg::CSR_FOOT_DROP:     drop_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_vis_ff;

`ifndef SYNTH
   // a finished result is not dropped while the output register is stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_DONE)
      else $error("finished result left ST_DONE while output stalled");

   // a point that is not visible has a zero screen position
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata[31:0] == 32'd0)
      else $error("hidden point with nonzero screen position");

   // a new result only comes from the finishing state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside ST_DONE");
`endif

endmodule

// ===== rtl/wsp_mul.sv =====
// ----------------------------------------------------------------------------
// wsp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wsp_mul (
   input  logic                                    clock,
   input  logic signed [wsp_pkg::MUL_OP_W-1:0]     op_a,
   input  logic signed [wsp_pkg::MUL_OP_W-1:0]     op_b,
   output logic signed [wsp_pkg::MUL_PROD_W-1:0]   product
);

   logic signed [wsp_pkg::MUL_PROD_W-1:0] product_ff;
   logic signed [wsp_pkg::MUL_PROD_W-1:0] product_in;

   // one product per cycle
   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/wsp_div.sv =====
// ----------------------------------------------------------------------------
// wsp_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsp_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [wsp_pkg::DIV_NUM_W-1:0]         dividend,
   input  logic [wsp_pkg::DIV_DEN_W-1:0]         divisor,
   output logic [wsp_pkg::DIV_NUM_W-1:0]         quotient,
   output wsp_pkg::wsp_div_status_type           status
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [wsp_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [wsp_pkg::DIV_DEN_W-1:0]     rem_ff, rem_in;
   logic [wsp_pkg::DIV_NUM_W-1:0]     quo_ff, quo_in;
   logic [wsp_pkg::DIV_DEN_W-1:0]     den_ff, den_in;
   logic [wsp_pkg::DIV_DEN_W:0]       trial;
   logic [wsp_pkg::DIV_DEN_W:0]       diff;
   logic                              ge;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, quo_ff[wsp_pkg::DIV_NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = wsp_pkg::DIV_CNT_W'(wsp_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[wsp_pkg::DIV_DEN_W-1:0] : trial[wsp_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[wsp_pkg::DIV_NUM_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient      = quo_ff;
   assign status.done   = done_ff;
   assign status.rem_nz = |rem_ff;

endmodule
